FILE: hdl/bts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bts_pkg
// Shared constants, scan mode codes and the per-byte result record of the
// brace template scanner.
// ----------------------------------------------------------------------------
package bts_pkg;

  // default nesting limit
  localparam int BTS_MAX_DEPTH = 255;

  // character codes
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_BTICK  = 8'h60;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  // scan modes
  localparam logic [2:0] MODE_TEXT  = 3'd0;
  localparam logic [2:0] MODE_OPEN  = 3'd1;
  localparam logic [2:0] MODE_CLOSE = 3'd2;
  localparam logic [2:0] MODE_EXPR  = 3'd3;
  localparam logic [2:0] MODE_QUOTE = 3'd4;
  localparam logic [2:0] MODE_ESC   = 3'd5;

  // quote kinds
  localparam logic [1:0] QK_NONE   = 2'd0;
  localparam logic [1:0] QK_SINGLE = 2'd1;
  localparam logic [1:0] QK_DOUBLE = 2'd2;
  localparam logic [1:0] QK_BTICK  = 2'd3;

  // classification of one byte
  typedef struct packed {
    logic [7:0] char_out;
    logic       to_text;
    logic       to_expr;
    logic       expr_open;
    logic       expr_close;
    logic       unterminated;
    logic       depth_overflow;
    logic       end_of_string;
  } bts_res_t;

  // closing character of a quote kind
  function automatic logic [7:0] quote_char(input logic [1:0] kind);
    logic [7:0] ch;
    case (kind)
      QK_SINGLE: ch = CH_SQUOTE;
      QK_DOUBLE: ch = CH_DQUOTE;
      default:   ch = CH_BTICK;
    endcase
    return ch;
  endfunction

endpackage

FILE: hdl/bts_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bts_scan
// Scanner state (mode, quote kind, nesting depth) and the single-pass
// classification of one byte against that state.
// ----------------------------------------------------------------------------
module bts_scan #(
  parameter int MAX_DEPTH = bts_pkg::BTS_MAX_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [7:0]        byte_in,
  input  logic              last,
  output bts_pkg::bts_res_t res
);
  import bts_pkg::*;

  localparam int DEPTH_W = (MAX_DEPTH < 2) ? 1 : $clog2(MAX_DEPTH + 1);
  localparam logic [DEPTH_W-1:0] DEPTH_MAX = DEPTH_W'(MAX_DEPTH);
  localparam logic [DEPTH_W-1:0] DEPTH_ONE = DEPTH_W'(1);

  logic [2:0]         mode_r,  mode_nxt;
  logic [1:0]         qkind_r, qkind_nxt;
  logic [DEPTH_W-1:0] depth_r, depth_nxt;
  logic               as_text, as_expr;

  // classify the byte and work out the next state
  always_comb begin
    res          = '0;
    res.char_out = byte_in;
    res.end_of_string = last;
    mode_nxt  = mode_r;
    qkind_nxt = qkind_r;
    depth_nxt = depth_r;
    as_text   = 1'b0;
    as_expr   = 1'b0;

    case (mode_r)
      MODE_CLOSE: begin
        if (byte_in == CH_RBRACE) begin
          res.to_text = 1'b1;
          mode_nxt    = MODE_TEXT;
        end else begin
          as_text = 1'b1;
        end
      end
      MODE_OPEN: begin
        if (byte_in == CH_LBRACE) begin
          res.to_text = 1'b1;
          mode_nxt    = MODE_TEXT;
        end else begin
          res.expr_open = 1'b1;
          depth_nxt     = DEPTH_ONE;
          mode_nxt      = MODE_EXPR;
          as_expr       = 1'b1;
        end
      end
      MODE_EXPR: begin
        as_expr = 1'b1;
      end
      MODE_QUOTE: begin
        res.to_expr = 1'b1;
        if (byte_in == CH_BSLASH) begin
          mode_nxt = MODE_ESC;
        end else if (byte_in == quote_char(qkind_r)) begin
          mode_nxt  = MODE_EXPR;
          qkind_nxt = QK_NONE;
        end
      end
      MODE_ESC: begin
        res.to_expr = 1'b1;
        mode_nxt    = MODE_QUOTE;
      end
      default: begin
        as_text = 1'b1;
      end
    endcase

    // plain text, single braces held pending
    if (as_text) begin
      if (byte_in == CH_LBRACE) begin
        mode_nxt = MODE_OPEN;
      end else if (byte_in == CH_RBRACE) begin
        mode_nxt = MODE_CLOSE;
      end else begin
        mode_nxt    = MODE_TEXT;
        res.to_text = 1'b1;
      end
    end

    // expression body: nesting and quote entry
    if (as_expr) begin
      if (byte_in == CH_LBRACE) begin
        res.to_expr = 1'b1;
        if (depth_nxt >= DEPTH_MAX) begin
          depth_nxt          = DEPTH_MAX;
          res.depth_overflow = 1'b1;
        end else begin
          depth_nxt = depth_nxt + DEPTH_ONE;
        end
      end else if (byte_in == CH_RBRACE) begin
        if (depth_nxt <= DEPTH_ONE) begin
          depth_nxt      = '0;
          res.expr_close = 1'b1;
          mode_nxt       = MODE_TEXT;
        end else begin
          depth_nxt   = depth_nxt - DEPTH_ONE;
          res.to_expr = 1'b1;
        end
      end else begin
        res.to_expr = 1'b1;
        if (byte_in == CH_SQUOTE) begin
          mode_nxt  = MODE_QUOTE;
          qkind_nxt = QK_SINGLE;
        end else if (byte_in == CH_DQUOTE) begin
          mode_nxt  = MODE_QUOTE;
          qkind_nxt = QK_DOUBLE;
        end else if (byte_in == CH_BTICK) begin
          mode_nxt  = MODE_QUOTE;
          qkind_nxt = QK_BTICK;
        end
      end
    end

    // end of string: flag open expressions and restart
    if (last) begin
      res.unterminated = (mode_nxt == MODE_EXPR) || (mode_nxt == MODE_QUOTE) ||
                         (mode_nxt == MODE_ESC);
      mode_nxt  = MODE_TEXT;
      qkind_nxt = QK_NONE;
      depth_nxt = '0;
    end
  end

  // state update on each processed byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_TEXT;
      qkind_r <= QK_NONE;
      depth_r <= '0;
    end else if (step) begin
      mode_r  <= mode_nxt;
      qkind_r <= qkind_nxt;
      depth_r <= depth_nxt;
    end
  end

endmodule

FILE: hdl/brace_template_scanner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brace_template_scanner
// Sorts template bytes into literal text and braced expression text.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one template byte per transfer (in_byte_in) with in_last on the
//           final byte of a string. valid/ready handshake.
//   out_* : one classification per input byte, in order: the byte itself,
//           where it goes (text, expression or dropped), expression open and
//           close marks, unterminated and depth overflow flags, and an echo
//           of in_last.
//   From input transfer to out_valid a byte passes an input register, then
//   the scan logic into the result register. Throughput is one byte per
//   cycle while the receiver does not stall; the scanner state (mode, quote
//   kind and nesting depth) is updated once for each byte taken.
//   When the receiver stalls the result register holds; the input register
//   still takes a byte if it is empty, and in_ready drops while it is full.
//   Reset clears both registers' valid flags and returns the scanner to text
//   mode with zero depth; the state also returns there after every last byte.
// ----------------------------------------------------------------------------
module brace_template_scanner #(
  parameter int MAX_DEPTH = bts_pkg::BTS_MAX_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte_in,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_char_out,
  output logic       out_to_text,
  output logic       out_to_expr,
  output logic       out_expr_open,
  output logic       out_expr_close,
  output logic       out_unterminated,
  output logic       out_depth_overflow,
  output logic       out_end_of_string
);
  import bts_pkg::*;

  logic       in_valid_r;
  logic [7:0] in_byte_r;
  logic       in_last_r;
  logic       out_valid_r;
  bts_res_t   res;
  bts_res_t   res_r;
  logic       advance;

  // move a byte from the input register into the result register
  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte_r <= in_byte_in;
      in_last_r <= in_last;
    end
  end

  bts_scan #(
    .MAX_DEPTH(MAX_DEPTH)
  ) u_scan (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (advance),
    .byte_in(in_byte_r),
    .last   (in_last_r),
    .res    (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_char_out       = res_r.char_out;
  assign out_to_text        = res_r.to_text;
  assign out_to_expr        = res_r.to_expr;
  assign out_expr_open      = res_r.expr_open;
  assign out_expr_close     = res_r.expr_close;
  assign out_unterminated   = res_r.unterminated;
  assign out_depth_overflow = res_r.depth_overflow;
  assign out_end_of_string  = res_r.end_of_string;

  // a byte goes to at most one destination
  a_one_dest: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_to_text && out_to_expr))
    else $error("byte sent to both text and expression");

  // the closing brace of an expression is dropped
  a_close_dropped: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_expr_close) |-> (!out_to_text && !out_to_expr))
    else $error("expression close brace was appended");

  // unterminated is only reported at the end of a string
  a_unterm_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_unterminated) |-> out_end_of_string)
    else $error("unterminated flagged before end of string");

  // an overflowing brace is still expression text
  a_ovf_expr: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_depth_overflow) |-> (out_to_expr && !out_to_text))
    else $error("overflow outside expression text");

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for brace_template_scanner: template strings go in one
// byte per transfer, and each returned classification is checked against a
// byte-level scanner model held in the bench. Directed strings, a nesting
// overflow string and random templates run under changing handshake stalls.
// ----------------------------------------------------------------------------
module tb;
  import bts_pkg::*;

  // clock, reset and block inputs, all known from time zero
  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_valid   = 1'b0;
  logic [7:0] in_byte_in = 8'h00;
  logic       in_last    = 1'b0;
  logic       out_ready  = 1'b0;

  logic       in_ready;
  logic       out_valid;
  logic [7:0] out_char_out;
  logic       out_to_text;
  logic       out_to_expr;
  logic       out_expr_open;
  logic       out_expr_close;
  logic       out_unterminated;
  logic       out_depth_overflow;
  logic       out_end_of_string;

  // stall rates in percent
  int unsigned snd_idle_pct = 0;
  int unsigned rcv_idle_pct = 0;

  // scanner model state
  logic [2:0] scan_st  = MODE_TEXT;
  logic [1:0] qkind_st = QK_NONE;
  int         depth_st = 0;

  // classifications still due from the block
  bts_res_t   predicted_tags[$];
  int         mismatch_cnt = 0;
  bts_res_t   got_tag;
  bts_res_t   want_tag;

  // template under construction
  logic [7:0] tmpl_q[$];

  brace_template_scanner DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_byte_in         (in_byte_in),
    .in_last            (in_last),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_char_out       (out_char_out),
    .out_to_text        (out_to_text),
    .out_to_expr        (out_to_expr),
    .out_expr_open      (out_expr_open),
    .out_expr_close     (out_expr_close),
    .out_unterminated   (out_unterminated),
    .out_depth_overflow (out_depth_overflow),
    .out_end_of_string  (out_end_of_string)
  );

  // 20 ns clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // receiver stalls, changed on the falling edge
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= rcv_idle_pct);
  end

  // model of one byte step, updates the scanner state
  function automatic bts_res_t classify_byte(input logic [7:0] b, input logic lst);
    bts_res_t   r;
    logic       txt_path;
    logic       expr_path;
    logic [7:0] close_ch;
    r = '0;
    r.char_out = b;
    r.end_of_string = lst;
    txt_path = 1'b0;
    expr_path = 1'b0;
    case (scan_st)
      MODE_CLOSE: begin
        scan_st = MODE_TEXT;
        if (b == CH_RBRACE) r.to_text = 1'b1;
        else txt_path = 1'b1;
      end
      MODE_OPEN: begin
        if (b == CH_LBRACE) begin
          r.to_text = 1'b1;
          scan_st = MODE_TEXT;
        end else begin
          r.expr_open = 1'b1;
          depth_st = 1;
          scan_st = MODE_EXPR;
          expr_path = 1'b1;
        end
      end
      MODE_EXPR: expr_path = 1'b1;
      MODE_QUOTE: begin
        r.to_expr = 1'b1;
        case (qkind_st)
          QK_SINGLE: close_ch = CH_SQUOTE;
          QK_DOUBLE: close_ch = CH_DQUOTE;
          default:   close_ch = CH_BTICK;
        endcase
        if (b == CH_BSLASH) begin
          scan_st = MODE_ESC;
        end else if (b == close_ch) begin
          scan_st = MODE_EXPR;
          qkind_st = QK_NONE;
        end
      end
      MODE_ESC: begin
        r.to_expr = 1'b1;
        scan_st = MODE_QUOTE;
      end
      default: txt_path = 1'b1;
    endcase

    // plain text handling, braces are held back one byte
    if (txt_path) begin
      scan_st = MODE_TEXT;
      if (b == CH_LBRACE) scan_st = MODE_OPEN;
      else if (b == CH_RBRACE) scan_st = MODE_CLOSE;
      else r.to_text = 1'b1;
    end

    // expression body: nesting and quote entry
    if (expr_path) begin
      if (b == CH_LBRACE) begin
        r.to_expr = 1'b1;
        if (depth_st >= BTS_MAX_DEPTH) begin
          depth_st = BTS_MAX_DEPTH;
          r.depth_overflow = 1'b1;
        end else begin
          depth_st = depth_st + 1;
        end
      end else if (b == CH_RBRACE) begin
        if (depth_st <= 1) begin
          depth_st = 0;
          r.expr_close = 1'b1;
          scan_st = MODE_TEXT;
        end else begin
          depth_st = depth_st - 1;
          r.to_expr = 1'b1;
        end
      end else begin
        r.to_expr = 1'b1;
        if (b == CH_SQUOTE) begin
          scan_st = MODE_QUOTE;
          qkind_st = QK_SINGLE;
        end else if (b == CH_DQUOTE) begin
          scan_st = MODE_QUOTE;
          qkind_st = QK_DOUBLE;
        end else if (b == CH_BTICK) begin
          scan_st = MODE_QUOTE;
          qkind_st = QK_BTICK;
        end
      end
    end

    // end of string flags and state clear
    if (lst) begin
      if (scan_st == MODE_EXPR || scan_st == MODE_QUOTE || scan_st == MODE_ESC)
        r.unterminated = 1'b1;
      scan_st = MODE_TEXT;
      qkind_st = QK_NONE;
      depth_st = 0;
    end
    return r;
  endfunction

  // one input transfer, entered and left at a falling edge
  task automatic push_byte(input logic [7:0] b, input logic lst);
    bts_res_t tag;
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_byte_in <= b;
    in_last    <= lst;
    do @(posedge clk); while (!in_ready);
    tag = classify_byte(b, lst);
    predicted_tags.insert(predicted_tags.size(), tag);
    @(negedge clk);
  endtask

  task automatic send_template();
    for (int i = 0; i < tmpl_q.size(); i++)
      push_byte(tmpl_q[i], i == tmpl_q.size() - 1);
  endtask

  // stop sending and wait for every due classification
  task automatic drain_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (predicted_tags.size() != 0) @(negedge clk);
  endtask

  // append one byte to the template
  function automatic void add_byte(input logic [7:0] b);
    tmpl_q.insert(tmpl_q.size(), b);
  endfunction

  // random byte that has no meaning to the scanner
  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    while (b == CH_LBRACE || b == CH_RBRACE || b == CH_SQUOTE || b == CH_DQUOTE ||
           b == CH_BTICK || b == CH_BSLASH)
      b = 8'($urandom_range(0, 255));
    return b;
  endfunction

  // quoted section with escapes and stray braces inside
  function automatic void add_quoted();
    logic [7:0] q;
    logic [7:0] b;
    int         n;
    case ($urandom_range(2))
      0:       q = CH_SQUOTE;
      1:       q = CH_DQUOTE;
      default: q = CH_BTICK;
    endcase
    add_byte(q);
    n = $urandom_range(0, 4);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(3) == 0) begin
        add_byte(CH_BSLASH);
        add_byte(8'($urandom_range(0, 255)));
      end else begin
        b = 8'($urandom_range(0, 255));
        while (b == q || b == CH_BSLASH) b = 8'($urandom_range(0, 255));
        add_byte(b);
      end
    end
    add_byte(q);
  endfunction

  // well-formed braced expression, possibly nested
  function automatic void add_expr(input int lvl);
    int n;
    int pick;
    add_byte(CH_LBRACE);
    if ($urandom_range(7) == 0) begin
      add_byte(CH_RBRACE);
      return;
    end
    add_byte(plain_byte());
    n = $urandom_range(0, 5);
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(9);
      if (pick >= 7 && lvl < 4) add_expr(lvl + 1);
      else if (pick >= 5 && pick < 7) add_quoted();
      else add_byte(plain_byte());
    end
    add_byte(CH_RBRACE);
  endfunction

  // random template: text, doubled braces, lone closing braces, expressions, quotes, noise
  function automatic void build_template();
    int n;
    int pick;
    int cut;
    tmpl_q.delete();
    n = $urandom_range(1, 8);
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(15);
      case (pick)
        0, 1, 2, 3, 4: begin
          for (int k = 0; k < $urandom_range(1, 4); k++) add_byte(plain_byte());
        end
        5: begin
          add_byte(CH_LBRACE);
          add_byte(CH_LBRACE);
        end
        6: begin
          add_byte(CH_RBRACE);
          add_byte(CH_RBRACE);
        end
        7:  add_byte(CH_RBRACE);
        13: add_byte(8'($urandom_range(0, 255)));
        14: add_quoted();
        default: add_expr(1);
      endcase
    end
    // some strings end early, possibly inside an expression or a quote
    if ($urandom_range(7) == 0) begin
      cut = $urandom_range(1, tmpl_q.size());
      while (tmpl_q.size() > cut) void'(tmpl_q.pop_back());
    end
  endfunction

  // directed strings: extremes, doubled braces, quotes and end cases
  task automatic test_directed();
    // doubled braces, lone closing brace then a byte that must survive
    tmpl_q = '{8'h00, CH_LBRACE, CH_LBRACE, CH_RBRACE, CH_RBRACE, CH_RBRACE, 8'hFF};
    send_template();
    // empty expression
    tmpl_q = '{CH_LBRACE, CH_RBRACE};
    send_template();
    // single quote with an escaped quote inside
    tmpl_q = '{CH_LBRACE, CH_SQUOTE, CH_BSLASH, CH_SQUOTE, CH_SQUOTE, CH_RBRACE};
    send_template();
    // double quote holding a backtick, then a backtick quote
    tmpl_q = '{CH_LBRACE, CH_DQUOTE, CH_BTICK, CH_DQUOTE, CH_BTICK, CH_BTICK, CH_RBRACE};
    send_template();
    // string ends inside an escape
    tmpl_q = '{CH_LBRACE, CH_SQUOTE, CH_BSLASH};
    send_template();
    // braces as the final byte
    tmpl_q = '{CH_RBRACE};
    send_template();
    tmpl_q = '{CH_LBRACE};
    send_template();
  endtask

  // nesting past the depth limit, then a clean string
  task automatic test_depth_overflow();
    tmpl_q.delete();
    add_byte(CH_LBRACE);
    add_byte(8'h61);
    for (int i = 0; i < BTS_MAX_DEPTH + 3; i++) add_byte(CH_LBRACE);
    add_byte(CH_RBRACE);
    send_template();
    tmpl_q = '{CH_LBRACE, 8'h62, CH_RBRACE};
    send_template();
  endtask

  task automatic test_random(input int n_bytes);
    int sent;
    sent = 0;
    while (sent < n_bytes) begin
      build_template();
      send_template();
      sent += tmpl_q.size();
    end
  endtask

  // result checker, one compare per output transfer
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      got_tag = {out_char_out, out_to_text, out_to_expr, out_expr_open, out_expr_close,
                 out_unterminated, out_depth_overflow, out_end_of_string};
      if (predicted_tags.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("unexpected result: actual %h", got_tag);
      end else begin
        want_tag = predicted_tags.pop_front();
        if (got_tag.char_out !== want_tag.char_out ||
            got_tag.to_text !== want_tag.to_text ||
            got_tag.to_expr !== want_tag.to_expr ||
            got_tag.expr_open !== want_tag.expr_open ||
            got_tag.expr_close !== want_tag.expr_close ||
            got_tag.unterminated !== want_tag.unterminated ||
            got_tag.depth_overflow !== want_tag.depth_overflow ||
            got_tag.end_of_string !== want_tag.end_of_string) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("mismatch: expected %h actual %h", want_tag, got_tag);
        end
      end
    end
  end

  // test sequence
  initial begin
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // sender stalls lightly, receiver heavily
    snd_idle_pct = 26;
    rcv_idle_pct = 85;
    test_directed();
    drain_results();
    test_depth_overflow();
    test_random(300);

    // sender stalls heavily, receiver lightly
    snd_idle_pct = 85;
    rcv_idle_pct = 26;
    test_random(300);

    // full rate
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    test_random(300);

    drain_results();
    repeat (10) @(posedge clk);
    if (mismatch_cnt == 0 && predicted_tags.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5000000;
    $display("FAILURE");
    $finish;
  end

endmodule

FILE: sim.f
hdl/bts_pkg.sv
hdl/bts_scan.sv
hdl/brace_template_scanner.sv
dv/tb.sv
